@@ rtl/iaqf_pkg.sv @@
// ----------------------------------------------------------------------------
// iaqf_pkg
// Shared types and constants of the attitude quaternion filter: sequencer
// states, accumulator modes, register indexes and the arctangent table.
// ----------------------------------------------------------------------------
package iaqf_pkg;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_GRAV,
		ST_AMAG,
		ST_ASQRT,
		ST_ADIV,
		ST_RCOR,
		ST_RDEG,
		ST_PSQ,
		ST_PSQRT,
		ST_PCOR,
		ST_PDEG,
		ST_ERR,
		ST_INTG,
		ST_RATE,
		ST_QSUM,
		ST_QSS,
		ST_QSQRT,
		ST_QDIV,
		ST_OUT
	} iaqf_state_t;

	typedef enum logic [2:0] {
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB,
		ACC_NEG,
		ACC_HI
	} iaqf_acc_t;

	localparam logic [1:0] CFG_KP = 2'd0;
	localparam logic [1:0] CFG_KI = 2'd1;
	localparam logic [1:0] CFG_HP = 2'd2;

	localparam logic [31:0] KP_RESET = 32'd655360;
	localparam logic [31:0] KI_RESET = 32'd21474836;
	localparam logic [31:0] HP_RESET = 32'd21474836;

	localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [33:0] DEG_Q16     = 34'sd3755213;
	localparam logic signed [48:0] Q_LIMIT     = 49'sd2147483647;
	localparam logic [63:0]        ONE_Q60     = 64'h1000_0000_0000_0000;

	localparam logic [4:0] SQRT_LAST = 5'd31;
	localparam logic [4:0] DIV_LAST  = 5'd30;
	localparam logic [4:0] COR_LAST  = 5'd29;

	function automatic logic [31:0] atan_tab(input logic [4:0] i);
		logic [31:0] t;
		unique case (i)
			5'd0:  t = 32'h3243F6A8;
			5'd1:  t = 32'h1DAC6705;
			5'd2:  t = 32'h0FADBAFC;
			5'd3:  t = 32'h07F56EA6;
			5'd4:  t = 32'h03FEAB76;
			5'd5:  t = 32'h01FFD55B;
			5'd6:  t = 32'h00FFFAAA;
			5'd7:  t = 32'h007FFF55;
			5'd8:  t = 32'h003FFFEA;
			5'd9:  t = 32'h001FFFFD;
			5'd10: t = 32'h000FFFFF;
			5'd11: t = 32'h0007FFFF;
			5'd12: t = 32'h0003FFFF;
			5'd13: t = 32'h0001FFFF;
			5'd14: t = 32'h0000FFFF;
			5'd15: t = 32'h00007FFF;
			5'd16: t = 32'h00003FFF;
			5'd17: t = 32'h00001FFF;
			5'd18: t = 32'h00000FFF;
			5'd19: t = 32'h000007FF;
			5'd20: t = 32'h000003FF;
			5'd21: t = 32'h000001FF;
			5'd22: t = 32'h000000FF;
			5'd23: t = 32'h0000007F;
			5'd24: t = 32'h0000003F;
			5'd25: t = 32'h0000001F;
			5'd26: t = 32'h0000000F;
			5'd27: t = 32'h00000008;
			5'd28: t = 32'h00000004;
			5'd29: t = 32'h00000002;
			default: t = 32'h00000000;
		endcase
		return t;
	endfunction

endpackage

@@ rtl/imu_attitude_quaternion_filter.sv @@
// ----------------------------------------------------------------------------
// imu_attitude_quaternion_filter
// Complementary attitude filter: PI gravity correction of the gyro rates,
// quaternion integration and renormalization, roll and pitch in degrees.
// One shared multiplier, square root, divider and rotator under a sequencer.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid, in_stall  | gyro_x/y/z, accel_x/y/z
//  out     | out_valid, out_stall| roll_deg, pitch_deg, updated
//  cfg     | cfg_valid, cfg_ready| cfg_index, cfg_data
//
//  an item that steps the filter reaches the output register through the sequencer
//  states, set mostly by the bit-serial divider (seven quotients) and square root
//  (three roots); a collapsed quaternion skips the last root and four quotients
//  an item with a zero accel component goes from ST_IDLE straight to ST_OUT
//  in_stall is high from acceptance until the result is in the output register
//  the output register holds a result while out_stall is high; no reset pass
// ----------------------------------------------------------------------------
module imu_attitude_quaternion_filter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] gyro_x,
	input  logic signed [31:0] gyro_y,
	input  logic signed [31:0] gyro_z,
	input  logic signed [31:0] accel_x,
	input  logic signed [31:0] accel_y,
	input  logic signed [31:0] accel_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] roll_deg,
	output logic signed [31:0] pitch_deg,
	output logic               updated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	iaqf_pkg::iaqf_state_t state_q, state_d;
	iaqf_pkg::iaqf_acc_t   acc_mode;

	logic        ph_q;
	logic [2:0]  k_q;
	logic [1:0]  c_q;
	logic [4:0]  it_q;

	logic [31:0] kp_q, ki_q, hp_q;

	logic signed [31:0] gy_q [3];
	logic signed [31:0] ac_q [3];
	logic signed [31:0] an_q [3];
	logic signed [35:0] e_q  [3];
	logic signed [31:0] g_q  [3];
	logic signed [31:0] ei_q [3];
	logic signed [31:0] q_q  [4];
	logic signed [31:0] n_q  [4];
	logic signed [33:0] vx_q, vy_q, vz_q;
	logic signed [31:0] roll_q, pitch_q;
	logic               upd_q;

	logic signed [69:0] acc_q, p_q, acc_nx;
	logic signed [35:0] mul_a;
	logic signed [33:0] mul_b;

	logic [62:0] sm_q;
	logic        sn_q;

	logic [63:0] sq_s_q, sq_r_q;
	logic [63:0] sq_bit;
	logic [5:0]  sq_sh;
	logic [64:0] sq_t;
	logic        sq_ge;

	logic [33:0] dv_rem_q, dv_rem_sh;
	logic [30:0] dv_quo_q, dv_quo_nx;
	logic [32:0] dv_d_q;
	logic        dv_neg_q, dv_b0_q, dv_ge;
	logic signed [31:0] dv_src, dv_res;
	logic [31:0] dv_mag;

	logic signed [37:0] cx_q, cy_q, cx_sh, cy_sh;
	logic signed [33:0] cz_q, c_tab;
	logic               cz0_q, cy_pos;
	logic signed [33:0] cor_y, cor_x;

	logic signed [33:0] s_w, rad_w;
	logic [33:0]        rad_mag;
	logic signed [69:0] deg_sum;
	logic signed [31:0] deg_m;

	logic signed [69:0] tr46, tr30;
	logic signed [69:0] dmag;
	logic signed [48:0] n_sum;

	logic in_acc, accel_zero, out_load;

	logic signed [31:0] roll_deg_q, pitch_deg_q;
	logic               updated_q, out_valid_q;

	function automatic logic signed [69:0] trunc_sh(input logic signed [69:0] v,
		input int unsigned sh);
		logic [69:0] m;
		m = v[69] ? 70'(-v) : 70'(v);
		m = m >> sh;
		return v[69] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -40'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	assign in_stall   = (state_q != iaqf_pkg::ST_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign accel_zero = (accel_x == 32'sd0) || (accel_y == 32'sd0) || (accel_z == 32'sd0);
	assign cfg_ready  = 1'b1;
	assign out_load   = (state_q == iaqf_pkg::ST_OUT) && (!out_valid_q || !out_stall);

	assign out_valid = out_valid_q;
	assign roll_deg  = roll_deg_q;
	assign pitch_deg = pitch_deg_q;
	assign updated   = updated_q;

	// shared datapath pieces
	always_comb begin
		unique case (acc_mode)
			iaqf_pkg::ACC_LOAD: acc_nx = p_q;
			iaqf_pkg::ACC_ADD:  acc_nx = acc_q + p_q;
			iaqf_pkg::ACC_SUB:  acc_nx = acc_q - p_q;
			iaqf_pkg::ACC_NEG:  acc_nx = -p_q;
			iaqf_pkg::ACC_HI:   acc_nx = p_q >>> 32;
			default:            acc_nx = p_q;
		endcase
	end

	assign sq_sh = 6'd62 - {it_q, 1'b0};
	assign sq_bit = 64'd1 << sq_sh;
	assign sq_t = {1'b0, sq_r_q} + {1'b0, sq_bit};
	assign sq_ge = ({1'b0, sq_s_q} >= sq_t);

	assign dv_rem_sh = {dv_rem_q[32:0], (it_q == 5'd0) ? dv_b0_q : 1'b0};
	assign dv_ge = (dv_rem_sh >= {1'b0, dv_d_q});
	assign dv_quo_nx = {dv_quo_q[29:0], dv_ge};
	assign dv_res = (dv_d_q == 33'd0) ? 32'sd0 :
		(dv_neg_q ? -$signed({1'b0, dv_quo_nx}) : $signed({1'b0, dv_quo_nx}));

	always_comb begin
		if (state_q == iaqf_pkg::ST_QDIV) begin
			dv_src = n_q[c_q];
		end else begin
			unique case (c_q)
				2'd0: dv_src = ac_q[0];
				2'd1: dv_src = ac_q[1];
				default: dv_src = ac_q[2];
			endcase
		end
	end
	assign dv_mag = dv_src[31] ? 32'(-dv_src) : 32'(dv_src);

	assign s_w = (vx_q > 34'sd1073741824) ? 34'sd1073741824 :
		((vx_q < -34'sd1073741824) ? -34'sd1073741824 : vx_q);
	assign cor_y = (state_q == iaqf_pkg::ST_PCOR) ? s_w : vy_q;
	assign cor_x = (state_q == iaqf_pkg::ST_PCOR) ? $signed({1'b0, sq_r_q[32:0]}) : vz_q;

	assign cx_sh = cx_q >>> it_q;
	assign cy_sh = cy_q >>> it_q;
	assign cy_pos = !cy_q[37] && (cy_q != 38'sd0);
	assign c_tab = $signed({2'b00, iaqf_pkg::atan_tab(it_q)});

	assign rad_w = cz0_q ? 34'sd0 : cz_q;
	assign rad_mag = rad_w[33] ? 34'(-rad_w) : 34'(rad_w);
	assign deg_sum = p_q + 70'sd536870912;
	assign deg_m = 32'(deg_sum >>> 30);

	assign tr46 = trunc_sh(p_q, 46);
	assign tr30 = trunc_sh(p_q, 30);
	assign dmag = acc_nx >>> 16;
	assign n_sum = 49'(q_q[c_q]) + (sn_q ? -49'(dmag) : 49'(dmag));

	// sequencer: next state and multiplier operands
	always_comb begin
		state_d  = state_q;
		mul_a    = '0;
		mul_b    = '0;
		acc_mode = iaqf_pkg::ACC_LOAD;
		unique case (state_q)
			iaqf_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = accel_zero ? iaqf_pkg::ST_OUT : iaqf_pkg::ST_GRAV;
				end
			end
			iaqf_pkg::ST_GRAV: begin
				unique case (k_q)
					3'd0: begin mul_a = 36'(q_q[1]); mul_b = 34'(q_q[3]); end
					3'd1: begin
						mul_a = 36'(q_q[0]); mul_b = 34'(q_q[2]);
						acc_mode = iaqf_pkg::ACC_SUB;
					end
					3'd2: begin mul_a = 36'(q_q[2]); mul_b = 34'(q_q[3]); end
					3'd3: begin
						mul_a = 36'(q_q[0]); mul_b = 34'(q_q[1]);
						acc_mode = iaqf_pkg::ACC_ADD;
					end
					3'd4: begin mul_a = 36'(q_q[0]); mul_b = 34'(q_q[0]); end
					3'd5: begin
						mul_a = 36'(q_q[1]); mul_b = 34'(q_q[1]);
						acc_mode = iaqf_pkg::ACC_SUB;
					end
					3'd6: begin
						mul_a = 36'(q_q[2]); mul_b = 34'(q_q[2]);
						acc_mode = iaqf_pkg::ACC_SUB;
					end
					default: begin
						mul_a = 36'(q_q[3]); mul_b = 34'(q_q[3]);
						acc_mode = iaqf_pkg::ACC_ADD;
					end
				endcase
				if (ph_q && k_q == 3'd7) begin
					state_d = iaqf_pkg::ST_AMAG;
				end
			end
			iaqf_pkg::ST_AMAG: begin
				mul_a = 36'(ac_q[k_q[1:0]]);
				mul_b = 34'(ac_q[k_q[1:0]]);
				acc_mode = (k_q == 3'd0) ? iaqf_pkg::ACC_LOAD : iaqf_pkg::ACC_ADD;
				if (ph_q && k_q == 3'd2) begin
					state_d = iaqf_pkg::ST_ASQRT;
				end
			end
			iaqf_pkg::ST_ASQRT: begin
				if (it_q == iaqf_pkg::SQRT_LAST) begin
					state_d = iaqf_pkg::ST_ADIV;
				end
			end
			iaqf_pkg::ST_ADIV: begin
				if (ph_q && it_q == iaqf_pkg::DIV_LAST && c_q == 2'd2) begin
					state_d = iaqf_pkg::ST_RCOR;
				end
			end
			iaqf_pkg::ST_RCOR: begin
				if (ph_q && it_q == iaqf_pkg::COR_LAST) begin
					state_d = iaqf_pkg::ST_RDEG;
				end
			end
			iaqf_pkg::ST_RDEG: begin
				mul_a = $signed({2'b00, rad_mag});
				mul_b = iaqf_pkg::DEG_Q16;
				if (ph_q) begin
					state_d = iaqf_pkg::ST_PSQ;
				end
			end
			iaqf_pkg::ST_PSQ: begin
				mul_a = 36'(s_w);
				mul_b = s_w;
				if (ph_q) begin
					state_d = iaqf_pkg::ST_PSQRT;
				end
			end
			iaqf_pkg::ST_PSQRT: begin
				if (it_q == iaqf_pkg::SQRT_LAST) begin
					state_d = iaqf_pkg::ST_PCOR;
				end
			end
			iaqf_pkg::ST_PCOR: begin
				if (ph_q && it_q == iaqf_pkg::COR_LAST) begin
					state_d = iaqf_pkg::ST_PDEG;
				end
			end
			iaqf_pkg::ST_PDEG: begin
				mul_a = $signed({2'b00, rad_mag});
				mul_b = iaqf_pkg::DEG_Q16;
				if (ph_q) begin
					state_d = iaqf_pkg::ST_ERR;
				end
			end
			iaqf_pkg::ST_ERR: begin
				unique case (k_q)
					3'd0: begin mul_a = 36'(an_q[1]); mul_b = vz_q; end
					3'd1: begin
						mul_a = 36'(an_q[2]); mul_b = vy_q;
						acc_mode = iaqf_pkg::ACC_SUB;
					end
					3'd2: begin mul_a = 36'(an_q[2]); mul_b = vx_q; end
					3'd3: begin
						mul_a = 36'(an_q[0]); mul_b = vz_q;
						acc_mode = iaqf_pkg::ACC_SUB;
					end
					3'd4: begin mul_a = 36'(an_q[0]); mul_b = vy_q; end
					default: begin
						mul_a = 36'(an_q[1]); mul_b = vx_q;
						acc_mode = iaqf_pkg::ACC_SUB;
					end
				endcase
				if (ph_q && k_q == 3'd5) begin
					state_d = iaqf_pkg::ST_INTG;
				end
			end
			iaqf_pkg::ST_INTG: begin
				mul_a = e_q[k_q[1:0]];
				mul_b = $signed({2'b00, ki_q});
				if (ph_q && k_q == 3'd2) begin
					state_d = iaqf_pkg::ST_RATE;
				end
			end
			iaqf_pkg::ST_RATE: begin
				mul_a = e_q[k_q[1:0]];
				mul_b = $signed({2'b00, kp_q});
				if (ph_q && k_q == 3'd2) begin
					state_d = iaqf_pkg::ST_QSUM;
				end
			end
			iaqf_pkg::ST_QSUM: begin
				unique case (k_q)
					3'd0: begin
						unique case (c_q)
							2'd0: begin
								mul_a = 36'(q_q[1]); mul_b = 34'(g_q[0]);
								acc_mode = iaqf_pkg::ACC_NEG;
							end
							2'd1: begin mul_a = 36'(q_q[0]); mul_b = 34'(g_q[0]); end
							2'd2: begin mul_a = 36'(q_q[0]); mul_b = 34'(g_q[1]); end
							default: begin mul_a = 36'(q_q[0]); mul_b = 34'(g_q[2]); end
						endcase
					end
					3'd1: begin
						unique case (c_q)
							2'd0: begin
								mul_a = 36'(q_q[2]); mul_b = 34'(g_q[1]);
								acc_mode = iaqf_pkg::ACC_SUB;
							end
							2'd1: begin
								mul_a = 36'(q_q[2]); mul_b = 34'(g_q[2]);
								acc_mode = iaqf_pkg::ACC_ADD;
							end
							2'd2: begin
								mul_a = 36'(q_q[1]); mul_b = 34'(g_q[2]);
								acc_mode = iaqf_pkg::ACC_SUB;
							end
							default: begin
								mul_a = 36'(q_q[1]); mul_b = 34'(g_q[1]);
								acc_mode = iaqf_pkg::ACC_ADD;
							end
						endcase
					end
					3'd2: begin
						unique case (c_q)
							2'd0: begin
								mul_a = 36'(q_q[3]); mul_b = 34'(g_q[2]);
								acc_mode = iaqf_pkg::ACC_SUB;
							end
							2'd1: begin
								mul_a = 36'(q_q[3]); mul_b = 34'(g_q[1]);
								acc_mode = iaqf_pkg::ACC_SUB;
							end
							2'd2: begin
								mul_a = 36'(q_q[3]); mul_b = 34'(g_q[0]);
								acc_mode = iaqf_pkg::ACC_ADD;
							end
							default: begin
								mul_a = 36'(q_q[2]); mul_b = 34'(g_q[0]);
								acc_mode = iaqf_pkg::ACC_SUB;
							end
						endcase
					end
					3'd3: begin
						mul_a = $signed({4'b0000, sm_q[31:0]});
						mul_b = $signed({2'b00, hp_q});
						acc_mode = iaqf_pkg::ACC_HI;
					end
					default: begin
						mul_a = $signed({5'b00000, sm_q[62:32]});
						mul_b = $signed({2'b00, hp_q});
						acc_mode = iaqf_pkg::ACC_ADD;
					end
				endcase
				if (ph_q && k_q == 3'd4 && c_q == 2'd3) begin
					state_d = iaqf_pkg::ST_QSS;
				end
			end
			iaqf_pkg::ST_QSS: begin
				mul_a = 36'(n_q[k_q[1:0]]);
				mul_b = 34'(n_q[k_q[1:0]]);
				acc_mode = (k_q == 3'd0) ? iaqf_pkg::ACC_LOAD : iaqf_pkg::ACC_ADD;
				if (ph_q && k_q == 3'd3) begin
					state_d = (acc_nx[63:0] == 64'd0) ? iaqf_pkg::ST_OUT : iaqf_pkg::ST_QSQRT;
				end
			end
			iaqf_pkg::ST_QSQRT: begin
				if (it_q == iaqf_pkg::SQRT_LAST) begin
					state_d = iaqf_pkg::ST_QDIV;
				end
			end
			iaqf_pkg::ST_QDIV: begin
				if (ph_q && it_q == iaqf_pkg::DIV_LAST && c_q == 2'd3) begin
					state_d = iaqf_pkg::ST_OUT;
				end
			end
			iaqf_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = iaqf_pkg::ST_IDLE;
				end
			end
			default: state_d = iaqf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iaqf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 1'b0;
			k_q  <= '0;
			c_q  <= '0;
			it_q <= '0;
		end else begin
			unique case (state_q)
				iaqf_pkg::ST_IDLE, iaqf_pkg::ST_OUT: begin
					ph_q <= 1'b0;
					k_q  <= '0;
					c_q  <= '0;
					it_q <= '0;
				end
				iaqf_pkg::ST_ASQRT, iaqf_pkg::ST_PSQRT, iaqf_pkg::ST_QSQRT: begin
					it_q <= it_q + 5'd1;
				end
				iaqf_pkg::ST_ADIV, iaqf_pkg::ST_QDIV: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
						it_q <= '0;
					end else if (it_q == iaqf_pkg::DIV_LAST) begin
						ph_q <= 1'b0;
						it_q <= '0;
						c_q  <= (state_d != state_q) ? 2'd0 : c_q + 2'd1;
					end else begin
						it_q <= it_q + 5'd1;
					end
				end
				iaqf_pkg::ST_RCOR, iaqf_pkg::ST_PCOR: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
						it_q <= '0;
					end else if (it_q == iaqf_pkg::COR_LAST) begin
						ph_q <= 1'b0;
						it_q <= '0;
					end else begin
						it_q <= it_q + 5'd1;
					end
				end
				iaqf_pkg::ST_QSUM: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (k_q == 3'd4) begin
							k_q <= '0;
							c_q <= c_q + 2'd1;
						end else begin
							k_q <= k_q + 3'd1;
						end
					end
				end
				default: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						k_q <= (state_d != state_q) ? 3'd0 : k_q + 3'd1;
					end
				end
			endcase
		end
	end

	// configuration and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= iaqf_pkg::KP_RESET;
			ki_q    <= iaqf_pkg::KI_RESET;
			hp_q    <= iaqf_pkg::HP_RESET;
			q_q[0]  <= iaqf_pkg::ONE_Q30;
			q_q[1]  <= '0;
			q_q[2]  <= '0;
			q_q[3]  <= '0;
			ei_q[0] <= '0;
			ei_q[1] <= '0;
			ei_q[2] <= '0;
			roll_q  <= '0;
			pitch_q <= '0;
			upd_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					iaqf_pkg::CFG_KP: kp_q <= cfg_data;
					iaqf_pkg::CFG_KI: ki_q <= cfg_data;
					iaqf_pkg::CFG_HP: hp_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc) begin
				upd_q <= !accel_zero;
			end
			if (state_q == iaqf_pkg::ST_RDEG && ph_q) begin
				roll_q <= rad_w[33] ? deg_m : -deg_m;
			end
			if (state_q == iaqf_pkg::ST_PDEG && ph_q) begin
				pitch_q <= rad_w[33] ? -deg_m : deg_m;
			end
			if (state_q == iaqf_pkg::ST_INTG && ph_q) begin
				ei_q[k_q[1:0]] <= sat32(40'(ei_q[k_q[1:0]]) + tr46[39:0]);
			end
			if (state_q == iaqf_pkg::ST_QDIV && ph_q && it_q == iaqf_pkg::DIV_LAST) begin
				q_q[c_q] <= dv_res;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		if (in_acc) begin
			gy_q[0] <= gyro_x;
			gy_q[1] <= gyro_y;
			gy_q[2] <= gyro_z;
			ac_q[0] <= accel_x;
			ac_q[1] <= accel_y;
			ac_q[2] <= accel_z;
		end
		unique case (state_q)
			iaqf_pkg::ST_GRAV: begin
				if (ph_q) begin
					acc_q <= acc_nx;
					if (k_q == 3'd1) vx_q <= 34'(acc_nx >>> 29);
					if (k_q == 3'd3) vy_q <= 34'(acc_nx >>> 29);
					if (k_q == 3'd7) vz_q <= 34'(acc_nx >>> 30);
				end
			end
			iaqf_pkg::ST_AMAG, iaqf_pkg::ST_QSS: begin
				if (ph_q) begin
					acc_q  <= acc_nx;
					sq_s_q <= acc_nx[63:0];
					sq_r_q <= '0;
				end
			end
			iaqf_pkg::ST_PSQ: begin
				if (ph_q) begin
					sq_s_q <= iaqf_pkg::ONE_Q60 - p_q[63:0];
					sq_r_q <= '0;
				end
			end
			iaqf_pkg::ST_ASQRT, iaqf_pkg::ST_PSQRT, iaqf_pkg::ST_QSQRT: begin
				if (sq_ge) begin
					sq_s_q <= sq_s_q - sq_t[63:0];
					sq_r_q <= (sq_r_q >> 1) + sq_bit;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
			end
			iaqf_pkg::ST_ADIV, iaqf_pkg::ST_QDIV: begin
				if (!ph_q) begin
					dv_d_q   <= sq_r_q[32:0];
					dv_neg_q <= dv_src[31];
					dv_rem_q <= {3'b000, dv_mag[31:1]};
					dv_b0_q  <= dv_mag[0];
					dv_quo_q <= '0;
				end else begin
					dv_rem_q <= dv_ge ? dv_rem_sh - {1'b0, dv_d_q} : dv_rem_sh;
					dv_quo_q <= dv_quo_nx;
					if (it_q == iaqf_pkg::DIV_LAST && state_q == iaqf_pkg::ST_ADIV) begin
						an_q[c_q] <= dv_res;
					end
				end
			end
			iaqf_pkg::ST_RCOR, iaqf_pkg::ST_PCOR: begin
				if (!ph_q) begin
					cz0_q <= (cor_x == 34'sd0) && (cor_y == 34'sd0);
					if (cor_x[33]) begin
						if (!cor_y[33]) begin
							cx_q <= 38'(cor_y);
							cy_q <= -38'(cor_x);
							cz_q <= iaqf_pkg::HALF_PI_Q30;
						end else begin
							cx_q <= -38'(cor_y);
							cy_q <= 38'(cor_x);
							cz_q <= -iaqf_pkg::HALF_PI_Q30;
						end
					end else begin
						cx_q <= 38'(cor_x);
						cy_q <= 38'(cor_y);
						cz_q <= '0;
					end
				end else if (cy_pos) begin
					cx_q <= cx_q + cy_sh;
					cy_q <= cy_q - cx_sh;
					cz_q <= cz_q + c_tab;
				end else begin
					cx_q <= cx_q - cy_sh;
					cy_q <= cy_q + cx_sh;
					cz_q <= cz_q - c_tab;
				end
			end
			iaqf_pkg::ST_ERR: begin
				if (ph_q) begin
					acc_q <= acc_nx;
					if (k_q[0]) e_q[k_q[2:1]] <= 36'(acc_nx >>> 30);
				end
			end
			iaqf_pkg::ST_RATE: begin
				if (ph_q) begin
					g_q[k_q[1:0]] <= sat32(40'(gy_q[k_q[1:0]]) + tr30[39:0]
						+ 40'(ei_q[k_q[1:0]]));
				end
			end
			iaqf_pkg::ST_QSUM: begin
				if (ph_q) begin
					acc_q <= acc_nx;
					if (k_q == 3'd2) begin
						sn_q <= acc_nx[69];
						sm_q <= acc_nx[69] ? 63'(-acc_nx) : 63'(acc_nx);
					end
					if (k_q == 3'd4) begin
						n_q[c_q] <= (n_sum > iaqf_pkg::Q_LIMIT) ? 32'(iaqf_pkg::Q_LIMIT) :
							((n_sum < -iaqf_pkg::Q_LIMIT) ? 32'(-iaqf_pkg::Q_LIMIT) :
							n_sum[31:0]);
					end
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			roll_deg_q  <= roll_q;
			pitch_deg_q <= pitch_q;
			updated_q   <= upd_q;
		end
	end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the attitude quaternion filter. A clocked driver
// and monitor run the item and result channels with random idle bursts; a
// bit-exact predictor of the filter state gives roll, pitch and the step flag
// for every accepted sample. Gains are changed between phases.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [1:0] CFG_NONE = 2'd3;
	localparam int         LIMIT_CYCLES = 4000000;
	localparam int         HOLD_CYCLES = 5000;
	localparam int         DRAIN_CYCLES = 600;
	localparam longint     Q30 = 64'sd1073741824;
	localparam longint     HALF_PI = 64'sd1686629713;
	localparam longint     QMAX = 64'sd2147483647;

	localparam longint ATAN [30] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
		64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
	};

	typedef struct {
		logic signed [31:0] gx, gy, gz, ax, ay, az;
	} sample_t;

	typedef struct {
		logic signed [31:0] roll, pitch;
		logic               stepped;
	} angles_t;

	logic               clk, arst_n;
	logic               in_valid, in_stall;
	logic signed [31:0] gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z;
	logic               out_valid, out_stall;
	logic signed [31:0] roll_deg, pitch_deg;
	logic               updated;
	logic               cfg_valid, cfg_ready;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;

	imu_attitude_quaternion_filter DUT (.*);

	// predictor state
	logic [31:0] gain_kp, gain_ki, gain_hp;
	longint      att_w, att_x, att_y, att_z, integ_x, integ_y, integ_z, held_roll, held_pitch;

	sample_t sample_q[$];
	angles_t angles_q[$];
	sample_t cur;
	int      tx_gap, rx_gap, hold_count, cycles;
	int      n_errors, n_items, n_results, n_skips;
	logic    quiet, hold_req, rx_hold;

	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	function automatic longint apply_sign(longint unsigned m, bit neg);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint unsigned isqrt(longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > s)
			b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint gain_mul(longint v, logic [31:0] g, int sh);
		longint unsigned p;
		p = mag(v) * longint'({32'b0, g});
		return apply_sign(p >> sh, v < 0);
	endfunction

	function automatic longint gain_mul_wide(longint v, logic [31:0] g);
		logic [95:0] p;
		p = {32'b0, mag(v)} * {64'b0, g};
		return apply_sign(64'(p[95:48]), v < 0);
	endfunction

	function automatic longint div_q30(longint a, longint unsigned r);
		if (r == 0)
			return 0;
		return apply_sign((mag(a) << 30) / r, a < 0);
	endfunction

	function automatic longint atan2_q30(longint y, longint x);
		longint z, t;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = HALF_PI;
			end else begin
				x = -y; y = t; z = -HALF_PI;
			end
		end
		for (int i = 0; i < 30; i++) begin
			t = x;
			if (y > 0) begin
				x = x + (y >>> i);
				y = y - (t >>> i);
				z = z + ATAN[i];
			end else begin
				x = x - (y >>> i);
				y = y + (t >>> i);
				z = z - ATAN[i];
			end
		end
		return z;
	endfunction

	function automatic longint to_deg(longint rad);
		return apply_sign((mag(rad) * 64'd3755213 + (64'd1 << 29)) >> 30, rad < 0);
	endfunction

	function automatic void filter_step(input sample_t s, output angles_t r);
		longint gx, gy, gz, ax, ay, az, w, x, y, z, vx, vy, vz, sp, ex, ey, ez;
		longint nw, nx, ny, nz;
		longint unsigned rr, ss;
		gx = s.gx; gy = s.gy; gz = s.gz;
		ax = s.ax; ay = s.ay; az = s.az;
		w = att_w; x = att_x; y = att_y; z = att_z;
		r.stepped = !(ax == 0 || ay == 0 || az == 0);
		if (r.stepped) begin
			vx = (x * z - w * y) >>> 29;
			vy = (y * z + w * x) >>> 29;
			vz = (w * w - x * x - y * y + z * z) >>> 30;
			held_roll = -to_deg(atan2_q30(vy, vz));
			sp = clampl(vx, -Q30, Q30);
			held_pitch = to_deg(atan2_q30(sp, longint'(isqrt(Q30 * Q30 - sp * sp))));

			rr = isqrt(mag(ax) * mag(ax) + mag(ay) * mag(ay) + mag(az) * mag(az));
			ax = div_q30(ax, rr);
			ay = div_q30(ay, rr);
			az = div_q30(az, rr);
			ex = (ay * vz - az * vy) >>> 30;
			ey = (az * vx - ax * vz) >>> 30;
			ez = (ax * vy - ay * vx) >>> 30;

			integ_x = clampl(integ_x + gain_mul(ex, gain_ki, 46), -(QMAX + 1), QMAX);
			integ_y = clampl(integ_y + gain_mul(ey, gain_ki, 46), -(QMAX + 1), QMAX);
			integ_z = clampl(integ_z + gain_mul(ez, gain_ki, 46), -(QMAX + 1), QMAX);
			gx = clampl(gx + gain_mul(ex, gain_kp, 30) + integ_x, -(QMAX + 1), QMAX);
			gy = clampl(gy + gain_mul(ey, gain_kp, 30) + integ_y, -(QMAX + 1), QMAX);
			gz = clampl(gz + gain_mul(ez, gain_kp, 30) + integ_z, -(QMAX + 1), QMAX);

			nw = clampl(w + gain_mul_wide(-x * gx - y * gy - z * gz, gain_hp), -QMAX, QMAX);
			nx = clampl(x + gain_mul_wide(w * gx + y * gz - z * gy, gain_hp), -QMAX, QMAX);
			ny = clampl(y + gain_mul_wide(w * gy - x * gz + z * gx, gain_hp), -QMAX, QMAX);
			nz = clampl(z + gain_mul_wide(w * gz + x * gy - y * gx, gain_hp), -QMAX, QMAX);
			ss = mag(nw) * mag(nw) + mag(nx) * mag(nx) + mag(ny) * mag(ny) + mag(nz) * mag(nz);
			// a collapsed quaternion keeps its old value
			if (ss != 0) begin
				rr = isqrt(ss);
				att_w = div_q30(nw, rr);
				att_x = div_q30(nx, rr);
				att_y = div_q30(ny, rr);
				att_z = div_q30(nz, rr);
			end
		end
		r.roll = held_roll[31:0];
		r.pitch = held_pitch[31:0];
	endfunction

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'd1;
			4: return 32'd65536;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] near(int span, bit nonzero);
		logic signed [31:0] v;
		v = $signed($urandom_range(0, 2 * span)) - span;
		if (nonzero && v == 0)
			v = 1;
		return v;
	endfunction

	function automatic sample_t rand_sample();
		sample_t s;
		int      mode;
		mode = $urandom_range(0, 99);
		if (mode < 60) begin
			// plausible motion: small rates, nonzero accel components within 1 << 17 of zero
			s.gx = near(1 << 17, 0); s.gy = near(1 << 17, 0); s.gz = near(1 << 17, 0);
			s.ax = near(1 << 17, 1); s.ay = near(1 << 17, 1); s.az = near(1 << 17, 1);
		end else if (mode < 85) begin
			s.gx = $urandom; s.gy = $urandom; s.gz = $urandom;
			s.ax = $urandom; s.ay = $urandom; s.az = $urandom;
		end else begin
			s.gx = pick_extreme(); s.gy = pick_extreme(); s.gz = pick_extreme();
			s.ax = pick_extreme(); s.ay = pick_extreme(); s.az = pick_extreme();
		end
		// a dropped accel axis skips the step
		if ($urandom_range(0, 9) == 0)
			case ($urandom_range(0, 2))
				0: s.ax = 0;
				1: s.ay = 0;
				default: s.az = 0;
			endcase
		return s;
	endfunction

	function automatic sample_t mk(int gx, int gy, int gz, int ax, int ay, int az);
		sample_t s;
		s.gx = gx; s.gy = gy; s.gz = gz; s.ax = ax; s.ay = ay; s.az = az;
		return s;
	endfunction

	function automatic void add_random(int n);
		for (int i = 0; i < n; i++)
			sample_q.push_back(rand_sample());
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// driver
	always @(posedge clk) begin
		angles_t a;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				filter_step(cur, a);
				angles_q.push_back(a);
				n_items++;
			end
			if (in_valid && in_stall) begin
			end else if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (sample_q.size() > 0) begin
				cur = sample_q.pop_front();
				gyro_x <= cur.gx; gyro_y <= cur.gy; gyro_z <= cur.gz;
				accel_x <= cur.ax; accel_y <= cur.ay; accel_z <= cur.az;
				in_valid <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0)
					tx_gap = $urandom_range(1, 12);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk)
		if (hold_req && hold_count < HOLD_CYCLES)
			hold_count <= hold_count + 1;
	assign rx_hold = hold_req && hold_count < HOLD_CYCLES;

	// monitor
	always @(posedge clk) begin
		angles_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (angles_q.size() == 0) begin
					$error("result with no sample pending");
					n_errors++;
				end else begin
					e = angles_q.pop_front();
					if (!updated)
						n_skips++;
					if (roll_deg !== e.roll) begin
						$error("roll_deg exp %0d got %0d", e.roll, roll_deg);
						n_errors++;
					end
					if (pitch_deg !== e.pitch) begin
						$error("pitch_deg exp %0d got %0d", e.pitch, pitch_deg);
						n_errors++;
					end
					if (updated !== e.stepped) begin
						$error("updated exp %0d got %0d", e.stepped, updated);
						n_errors++;
					end
				end
			end
			if (rx_gap == 0 && !quiet && $urandom_range(0, 5) == 0)
				rx_gap = $urandom_range(1, 12);
			out_stall <= rx_hold || rx_gap > 0;
			if (rx_gap > 0)
				rx_gap--;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			iaqf_pkg::CFG_KP: gain_kp = val;
			iaqf_pkg::CFG_KI: gain_ki = val;
			iaqf_pkg::CFG_HP: gain_hp = val;
			default: ;
		endcase
	endtask

	task automatic set_gains(input logic [31:0] kp, input logic [31:0] ki,
			input logic [31:0] hp);
		wait_idle();
		write_reg(iaqf_pkg::CFG_KP, kp);
		write_reg(iaqf_pkg::CFG_KI, ki);
		write_reg(iaqf_pkg::CFG_HP, hp);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (sample_q.size() != 0 || in_valid || angles_q.size() != 0);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0; out_stall = 1'b0; cfg_valid = 1'b0;
		cfg_index = iaqf_pkg::CFG_KP; cfg_data = '0;
		gyro_x = '0; gyro_y = '0; gyro_z = '0;
		accel_x = '0; accel_y = '0; accel_z = '0;
		quiet = 1'b0; hold_req = 1'b0; hold_count = 0; cycles = 0;
		tx_gap = 0; rx_gap = 0;
		n_errors = 0; n_items = 0; n_results = 0; n_skips = 0;
		gain_kp = iaqf_pkg::KP_RESET; gain_ki = iaqf_pkg::KI_RESET;
		gain_hp = iaqf_pkg::HP_RESET;
		att_w = Q30; att_x = 0; att_y = 0; att_z = 0;
		integ_x = 0; integ_y = 0; integ_z = 0; held_roll = 0; held_pitch = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults
		sample_q.push_back(mk(0, 0, 0, 0, 0, 0));
		sample_q.push_back(mk(0, 0, 0, 1, 1, 65536));
		sample_q.push_back(mk(65536, 0, 0, 65536, 0, 65536));
		sample_q.push_back(mk(0, 65536, 0, 0, 65536, 65536));
		sample_q.push_back(mk(0, 0, 65536, 65536, 65536, 0));
		sample_q.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
		sample_q.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000));
		sample_q.push_back(mk(1, -1, 1, -1, -1, -1));
		sample_q.push_back(mk(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
		for (int i = 0; i < 6; i++)
			sample_q.push_back(mk(32'h7FFFFFFF, 0, 0, 1, 1, 1));
		for (int i = 0; i < 4; i++)
			sample_q.push_back(mk(0, 32'h80000000, 0, -65536, 3, -65536));
		sample_q.push_back(mk(0, 0, 0, 65536, 65536, 0));
		add_random(180);

		set_gains(32'd0, 32'd0, 32'd0);
		add_random(100);

		set_gains(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		add_random(100);

		// receiver holds off while the sender keeps offering
		set_gains(32'd1310720, $urandom, $urandom_range(0, 32'h0800_0000));
		write_reg(CFG_NONE, $urandom);
		cfg_valid <= 1'b0;
		hold_req <= 1'b1;
		add_random(150);

		for (int p = 0; p < 4; p++) begin
			set_gains($urandom, $urandom, $urandom);
			add_random(50);
		end

		set_gains(iaqf_pkg::KP_RESET, iaqf_pkg::KI_RESET, iaqf_pkg::HP_RESET);
		quiet = 1'b1;
		add_random(200);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d samples, %0d results, %0d skipped steps, gains swept over 9 settings",
			n_items, n_results, n_skips);
		if (n_errors == 0 && angles_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
